[hdl/iss_pkg.sv]
// shared types and constants for the interval schedule selector
package iss_pkg;

  // width of the activity number on the result channel
  localparam int NUMBER_BITS = 6;

  // control state, one-hot
  typedef enum logic [1:0] {
    ST_LOAD  = 2'b01,
    ST_DRAIN = 2'b10
  } state_t;

  // per-cycle command broadcast to every cell of the chain
  typedef struct packed {
    logic ins;    // sorted insert of the incoming request
    logic shift;  // move every entry one cell toward the head
  } cell_ctrl_t;

endpackage

[hdl/iss_cell.sv]
// one cell of the sorted chain: holds one activity, trades with its neighbors
module iss_cell #(
  parameter int TIME_BITS = 16,
  parameter int NUM_BITS  = 5
) (
  input  logic                 clk,
  input  logic                 rst,
  input  iss_pkg::cell_ctrl_t  ctrl,
  // incoming activity
  input  logic [TIME_BITS-1:0] new_start,
  input  logic [TIME_BITS-1:0] new_finish,
  input  logic [NUM_BITS-1:0]  new_num,
  // neighbor toward the head
  input  logic                 prev_keep,
  input  logic                 prev_valid,
  input  logic [TIME_BITS-1:0] prev_start,
  input  logic [TIME_BITS-1:0] prev_finish,
  input  logic [NUM_BITS-1:0]  prev_num,
  // neighbor toward the tail
  input  logic                 next_valid,
  input  logic [TIME_BITS-1:0] next_start,
  input  logic [TIME_BITS-1:0] next_finish,
  input  logic [NUM_BITS-1:0]  next_num,
  // own contents
  output logic                 keep,
  output logic                 valid,
  output logic [TIME_BITS-1:0] start,
  output logic [TIME_BITS-1:0] finish,
  output logic [NUM_BITS-1:0]  num
);

  // entry stays put when it finishes no later than the new one (stable order)
  assign keep = valid && !(finish > new_finish);

  // valid bit
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.shift) begin
      valid <= next_valid;
    end else if (ctrl.ins && !keep) begin
      valid <= prev_keep ? 1'b1 : prev_valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      start  <= next_start;
      finish <= next_finish;
      num    <= next_num;
    end else if (ctrl.ins && !keep) begin
      if (prev_keep) begin
        start  <= new_start;
        finish <= new_finish;
        num    <= new_num;
      end else begin
        start  <= prev_start;
        finish <= prev_finish;
        num    <= prev_num;
      end
    end
  end

endmodule

[hdl/interval_schedule_select.sv]
// greedy earliest-finish activity selection over a sorted insert chain
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid in_ready start_time finish_time  | request in
//          | last_item                                 |
//  out     | out_valid out_ready activity_number       | result out
//          | last_result                               |
//
// While loading, the chain of cells sorts each activity into place by
// finish time as it arrives. After the request marked last, the chain
// drains through its head cell, one activity per cycle unless stalled.
// Reset clears the valid bits, the count and the last chosen finish.
// A held result in the output register stalls draining only when the
// next chosen activity needs that register; no request is taken while
// draining.
module interval_schedule_select #(
  parameter int MAX_ACTIVITIES = 32,
  parameter int TIME_BITS      = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [TIME_BITS-1:0]            start_time,
  input  logic [TIME_BITS-1:0]            finish_time,
  input  logic                            last_item,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [iss_pkg::NUMBER_BITS-1:0] activity_number,
  output logic                            last_result
);

  localparam int NUM_BITS = (MAX_ACTIVITIES > 1) ? $clog2(MAX_ACTIVITIES) : 1;
  localparam int CNT_BITS = $clog2(MAX_ACTIVITIES + 1);

  iss_pkg::state_t    state;
  iss_pkg::cell_ctrl_t ctrl;

  logic [CNT_BITS-1:0]              cnt;
  logic [TIME_BITS-1:0]             last_finish;
  logic                             first;
  logic                             pend_valid;
  logic [iss_pkg::NUMBER_BITS-1:0]  pend_num;

  logic                 c_keep   [MAX_ACTIVITIES];
  logic                 c_valid  [MAX_ACTIVITIES];
  logic [TIME_BITS-1:0] c_start  [MAX_ACTIVITIES];
  logic [TIME_BITS-1:0] c_finish [MAX_ACTIVITIES];
  logic [NUM_BITS-1:0]  c_num    [MAX_ACTIVITIES];

  logic full;
  logic out_free;
  logic head_chosen;
  logic done;

  // chain of cells
  for (genvar i = 0; i < MAX_ACTIVITIES; i++) begin : g_cell
    logic                 p_keep;
    logic                 p_valid;
    logic [TIME_BITS-1:0] p_start;
    logic [TIME_BITS-1:0] p_finish;
    logic [NUM_BITS-1:0]  p_num;
    logic                 n_valid;
    logic [TIME_BITS-1:0] n_start;
    logic [TIME_BITS-1:0] n_finish;
    logic [NUM_BITS-1:0]  n_num;

    if (i == 0) begin : g_head
      assign p_keep   = 1'b1;
      assign p_valid  = 1'b0;
      assign p_start  = '0;
      assign p_finish = '0;
      assign p_num    = '0;
    end else begin : g_body
      assign p_keep   = c_keep[i-1];
      assign p_valid  = c_valid[i-1];
      assign p_start  = c_start[i-1];
      assign p_finish = c_finish[i-1];
      assign p_num    = c_num[i-1];
    end

    if (i == MAX_ACTIVITIES - 1) begin : g_tail
      assign n_valid  = 1'b0;
      assign n_start  = '0;
      assign n_finish = '0;
      assign n_num    = '0;
    end else begin : g_inner
      assign n_valid  = c_valid[i+1];
      assign n_start  = c_start[i+1];
      assign n_finish = c_finish[i+1];
      assign n_num    = c_num[i+1];
    end

    iss_cell #(
      .TIME_BITS (TIME_BITS),
      .NUM_BITS  (NUM_BITS)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctrl        (ctrl),
      .new_start   (start_time),
      .new_finish  (finish_time),
      .new_num     (cnt[NUM_BITS-1:0]),
      .prev_keep   (p_keep),
      .prev_valid  (p_valid),
      .prev_start  (p_start),
      .prev_finish (p_finish),
      .prev_num    (p_num),
      .next_valid  (n_valid),
      .next_start  (n_start),
      .next_finish (n_finish),
      .next_num    (n_num),
      .keep        (c_keep[i]),
      .valid       (c_valid[i]),
      .start       (c_start[i]),
      .finish      (c_finish[i]),
      .num         (c_num[i])
    );
  end

  // chain commands and greedy decision at the head cell
  always_comb begin
    full        = (cnt == CNT_BITS'(MAX_ACTIVITIES));
    out_free    = !out_valid || out_ready;
    head_chosen = first || !(c_start[0] < last_finish);
    in_ready    = (state == iss_pkg::ST_LOAD);
    ctrl.ins    = in_ready && in_valid && !full;
    ctrl.shift  = (state == iss_pkg::ST_DRAIN) && c_valid[0] &&
                  (!head_chosen || !pend_valid || out_free);
    done        = (state == iss_pkg::ST_DRAIN) && !c_valid[0] &&
                  (!pend_valid || out_free);
  end

  // state, batch count and first flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= iss_pkg::ST_LOAD;
      cnt   <= '0;
      first <= 1'b0;
    end else begin
      case (state)
        iss_pkg::ST_LOAD: begin
          if (ctrl.ins) begin
            cnt <= cnt + CNT_BITS'(1);
          end
          if (in_valid && last_item) begin
            state <= iss_pkg::ST_DRAIN;
            first <= 1'b1;
          end
        end
        iss_pkg::ST_DRAIN: begin
          if (ctrl.shift && head_chosen) begin
            first <= 1'b0;
          end
          if (done) begin
            state <= iss_pkg::ST_LOAD;
            cnt   <= '0;
          end
        end
        default: begin
          state <= iss_pkg::ST_LOAD;
        end
      endcase
    end
  end

  // pending chosen activity, held until we know whether it is the final one
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid  <= 1'b0;
      last_finish <= '0;
    end else if (ctrl.shift && head_chosen) begin
      pend_valid  <= 1'b1;
      last_finish <= c_finish[0];
    end else if (done) begin
      pend_valid  <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.shift && head_chosen) begin
      pend_num <= iss_pkg::NUMBER_BITS'({1'b0, c_num[0]} + (NUM_BITS + 1)'(1));
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((ctrl.shift && head_chosen && pend_valid) || (done && pend_valid)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((ctrl.shift && head_chosen && pend_valid) || (done && pend_valid)) begin
      activity_number <= pend_num;
      last_result     <= done;
    end
  end

endmodule
